// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define AST_CLKD(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define AST_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tlfm_pkg.sv =====
// Package: shared types and constants of the tabu list
package tlfm_pkg;

    localparam int KIND_W         = 8;
    localparam int LIMIT_W        = 5;
    localparam int DEPTH_DEF      = 16;
    localparam int INDEX_BITS_DEF = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic shift;
        logic load;
        logic query;
        logic ordered;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/tlfm_cell.sv =====
// One list cell: holds one entry, shifts it onward on insert, matches queries
module tlfm_cell import tlfm_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic                  live,
    input  logic [KIND_W-1:0]     prev_kind,
    input  logic [INDEX_BITS-1:0] prev_first,
    input  logic [INDEX_BITS-1:0] prev_second,
    input  logic [KIND_W-1:0]     q_kind,
    input  logic [INDEX_BITS-1:0] q_first,
    input  logic [INDEX_BITS-1:0] q_second,
    output logic [KIND_W-1:0]     kind,
    output logic [INDEX_BITS-1:0] first,
    output logic [INDEX_BITS-1:0] second,
    output logic                  hit
);

    logic [KIND_W-1:0]     kind_reg;
    logic [INDEX_BITS-1:0] first_reg;
    logic [INDEX_BITS-1:0] second_reg;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  exact;
    logic                  swapped;

    assign exact    = (first_reg == q_first) && (second_reg == q_second);
    assign swapped  = (first_reg == q_second) && (second_reg == q_first);
    assign hit_next = ctrl.query && live && (kind_reg == q_kind)
                      && (exact || (!ctrl.ordered && swapped));

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            kind_reg   <= prev_kind;
            first_reg  <= prev_first;
            second_reg <= prev_second;
        end
        if (ctrl.load)
        begin
            hit_reg <= hit_next;
        end
    end

    assign kind   = kind_reg;
    assign first  = first_reg;
    assign second = second_reg;
    assign hit    = hit_reg;

endmodule

// ===== rtl/core/tabu_list_fifo_match.sv =====
// Top level: bounded FIFO tabu list built as a shifting chain of match cells
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, mode, move_kind, indices,   | sink
//          | ordered_only                                    |
//  out     | out_valid, out_stall, is_forbidden, entries_held| source
//  cfg     | cfg_we, cfg_wdata (list_limit)                  | sink
//
// One beat per cycle while in_stall is low; each result is registered in the
// per-cell match register and then in the output register of the OR stage behind it.
// Reset clears the fill count and pipeline valids; list_limit returns to 16.
// A stalled result holds a valid middle stage, and in_stall is raised combinationally while it holds.
module tabu_list_fifo_match import tlfm_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [LIMIT_W-1:0]               cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [KIND_W-1:0]                move_kind,
    input  logic [INDEX_BITS-1:0]            index_first,
    input  logic [INDEX_BITS-1:0]            index_second,
    input  logic                             ordered_only,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             is_forbidden,
    output logic [$clog2(DEPTH+1)-1:0]       entries_held
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [CNT_W-1:0]   lim_eff;
    logic               a_valid_reg;
    logic [CNT_W-1:0]   a_held_reg;
    logic               out_valid_reg;
    logic               is_forbidden_reg;
    logic [CNT_W-1:0]   entries_held_reg;

    logic               accept;
    logic               a_advance;
    logic               do_shift;
    cell_ctrl_t         ctrl;

    logic [KIND_W-1:0]     chain_kind   [DEPTH+1];
    logic [INDEX_BITS-1:0] chain_first  [DEPTH+1];
    logic [INDEX_BITS-1:0] chain_second [DEPTH+1];
    logic [DEPTH-1:0]      cell_hit;
    logic [DEPTH-1:0]      cell_live;

    assign lim_eff = (32'(limit_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(limit_reg);

    assign a_advance = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = a_valid_reg && !a_advance;
    assign accept    = in_valid && !in_stall;
    assign do_shift  = accept && (mode == MODE_INSERT) && (lim_eff != '0);

    always_comb
    begin
        fill_next = fill_reg;
        if (do_shift)
        begin
            fill_next = (fill_reg >= lim_eff) ? lim_eff : fill_reg + 1'b1;
        end
    end

    assign ctrl.shift   = do_shift;
    assign ctrl.load    = accept;
    assign ctrl.query   = (mode == MODE_QUERY);
    assign ctrl.ordered = ordered_only;

    assign chain_kind[0]   = move_kind;
    assign chain_first[0]  = index_first;
    assign chain_second[0] = index_second;

    // cell 0 holds the newest entry
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        assign cell_live[k] = (fill_reg > CNT_W'(k));

        tlfm_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .live        (cell_live[k]),
            .prev_kind   (chain_kind[k]),
            .prev_first  (chain_first[k]),
            .prev_second (chain_second[k]),
            .q_kind      (move_kind),
            .q_first     (index_first),
            .q_second    (index_second),
            .kind        (chain_kind[k+1]),
            .first       (chain_first[k+1]),
            .second      (chain_second[k+1]),
            .hit         (cell_hit[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            fill_reg      <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_held_reg <= fill_next;
        end
        if (a_advance)
        begin
            is_forbidden_reg <= |cell_hit;
            entries_held_reg <= a_held_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_forbidden = is_forbidden_reg;
    assign entries_held = entries_held_reg;

endmodule

// ===== rtl/core/tlfm_checker.sv =====
// Checker on the top-level ports of the tabu list, bound to the top level
`include "assert_macros.svh"

module tlfm_checker import tlfm_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       is_forbidden,
    input logic [$clog2(DEPTH+1)-1:0] entries_held,
    input logic [INDEX_BITS-1:0]      index_first
);

    logic idx_seen;

    assign idx_seen = ^index_first || !(^index_first);

    `AST_CLKD(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")
    `AST_CLKD(a_empty_nohit, out_valid && idx_seen && entries_held == '0 |-> !is_forbidden, "hit on empty list")
    `AST_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with output free")

endmodule

bind tabu_list_fifo_match tlfm_checker #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS)
) u_tlfm_checker (.*);
